// ===== hdl/grid_local_peak_finder_macros.svh =====
// Assertion macros for the grid local peak finder checker.
// Expects clk and arst_n in scope where the macros are used.
`ifndef GRID_LOCAL_PEAK_FINDER_MACROS_SVH
`define GRID_LOCAL_PEAK_FINDER_MACROS_SVH

// Check a property on the rising clock edge, off while reset is asserted.
`define GLPF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A stalled word keeps its valid and its contents.
`define GLPF_ASSERT_HOLD(label, vld, rdy, sig) \
	`GLPF_ASSERT(label, (vld && !rdy) |=> (vld && $stable(sig)), "word changed while stalled")

`endif

// ===== hdl/glpf_pkg.sv =====
// Types and constants shared by the grid local peak finder modules.
// No dependencies.
`timescale 1ns / 1ps
package glpf_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int ROW_BITS    = 10;
	localparam int COL_BITS    = 10;
	localparam int SIZE_BITS   = 11;
	localparam int SIZE_MAX    = (2 ** SIZE_BITS) - 1;

	localparam int MAX_HEIGHT = 1024;
	localparam logic [SIZE_BITS-1:0] HEIGHT_LIMIT = SIZE_BITS'(MAX_HEIGHT);

	localparam logic [SIZE_BITS-1:0] FRAME_WIDTH_RESET  = SIZE_BITS'(5);
	localparam logic [SIZE_BITS-1:0] FRAME_HEIGHT_RESET = SIZE_BITS'(4);

	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = CFG_INDEX_BITS'(1);

	localparam int RES_SLOTS = 3;
	localparam int RES_ABOVE = 0;
	localparam int RES_LEFT  = 1;
	localparam int RES_FINAL = 2;

	localparam int QUEUE_DEPTH      = 4;
	localparam int PTR_BITS         = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

	localparam int OUT_FIELD_BITS = ROW_BITS + COL_BITS + SAMPLE_BITS;
	localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_BITS   = OUT_DATA_BITS - OUT_FIELD_BITS;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic [SIZE_BITS-1:0] width;
		logic [SIZE_BITS-1:0] height;
		logic                 restart;
	} frame_cfg_t;

	typedef struct packed {
		logic [RES_SLOTS-1:0] present;
		logic [RES_SLOTS-1:0] peak;
		logic [ROW_BITS-1:0]  row;
		logic [COL_BITS-1:0]  col;
		sample_t              val_above;
		sample_t              val_left;
		sample_t              val_final;
	} result_set_t;

	typedef struct packed {
		logic [OUT_PAD_BITS-1:0] pad;
		sample_t                 value;
		logic [COL_BITS-1:0]     col;
		logic [ROW_BITS-1:0]     row;
	} out_word_t;

endpackage

// ===== hdl/grid_local_peak_finder.sv =====
// Top level of the grid local peak finder: configuration registers and stage wiring.
// Depends on glpf_pkg, glpf_front, glpf_queue and glpf_back.
//
// Samples enter on s_axis in raster order, one word per sample. For every sample
// decided, one word leaves on m_axis: row, column and value in tdata, the peak flag
// in tuser, and tlast on the last word caused by one input word.
// The cfg channel writes frame_width (index 0) or frame_height (index 1) and
// restarts the frame at row 0, column 0; cfg_ready is always high.
// Write configuration only while no words are in flight.
// The first word of a sample passes stage 1, the queue and the output register.
// One input and one output word per cycle while m_axis_tready is high; in the last
// row a sample yields up to three words, so there the output rate sets the pace.
// The line RAM is MAX_WIDTH x 32 bits with one write and two reads per cycle.
// Reset sets the frame to 5 x 4 and the position to row 0, column 0 and empties the
// queue; the line RAM is not cleared, a frame only reads columns it has written.
// A four-entry queue and the output register absorb receiver stalls; s_axis_tready
// falls once the queue level plus the stage-1 word reaches four.
`timescale 1ns / 1ps
module grid_local_peak_finder import glpf_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [SAMPLE_BITS-1:0]    s_axis_tdata,  // [15:0] sample_value
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,  // [9:0] peak_row, [19:10] peak_column,
	                                                 // [35:20] peak_value, [39:36] zero
	output logic                      m_axis_tuser,  // [0] is_peak
	output logic                      m_axis_tlast,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [SIZE_BITS-1:0]      cfg_data
);

	localparam int WIDTH_CLIP = (MAX_WIDTH > SIZE_MAX) ? SIZE_MAX : MAX_WIDTH;
	localparam logic [SIZE_BITS-1:0] WIDTH_LIMIT = SIZE_BITS'(WIDTH_CLIP);

	logic [SIZE_BITS-1:0]        frame_width_q, frame_height_q;
	frame_cfg_t                  frame_cfg;
	logic                        cfg_write;
	logic                        push, pop, head_valid;
	result_set_t                 push_set, head_set;
	logic [QUEUE_COUNT_BITS-1:0] queue_level;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RESET;
			frame_height_q <= FRAME_HEIGHT_RESET;
		end else if (cfg_write) begin
			if (cfg_index == CFG_FRAME_WIDTH) begin
				frame_width_q <= cfg_data;
			end
			if (cfg_index == CFG_FRAME_HEIGHT) begin
				frame_height_q <= cfg_data;
			end
		end
	end

	always_comb begin
		frame_cfg = '0;
		if (frame_width_q == '0) begin
			frame_cfg.width = SIZE_BITS'(1);
		end else if (frame_width_q > WIDTH_LIMIT) begin
			frame_cfg.width = WIDTH_LIMIT;
		end else begin
			frame_cfg.width = frame_width_q;
		end
		if (frame_height_q == '0) begin
			frame_cfg.height = SIZE_BITS'(1);
		end else if (frame_height_q > HEIGHT_LIMIT) begin
			frame_cfg.height = HEIGHT_LIMIT;
		end else begin
			frame_cfg.height = frame_height_q;
		end
		frame_cfg.restart = cfg_write &&
			((cfg_index == CFG_FRAME_WIDTH) || (cfg_index == CFG_FRAME_HEIGHT));
	end

	glpf_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_sample   (s_axis_tdata),
		.frame_cfg   (frame_cfg),
		.queue_level (queue_level),
		.push        (push),
		.push_set    (push_set)
	);

	glpf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_set   (push_set),
		.pop        (pop),
		.head_valid (head_valid),
		.head_set   (head_set),
		.level      (queue_level)
	);

	glpf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_set   (head_set),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_peak   (m_axis_tuser),
		.out_last   (m_axis_tlast)
	);

endmodule

// ===== hdl/glpf_front.sv =====
// Front end: frame position, line RAM and four-neighbour classification.
// Depends on glpf_pkg; pushes one result set per deciding sample into glpf_queue.
`timescale 1ns / 1ps
module glpf_front import glpf_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  sample_t                     in_sample,
	input  frame_cfg_t                  frame_cfg,
	input  logic [QUEUE_COUNT_BITS-1:0] queue_level,
	output logic                        push,
	output result_set_t                 push_set
);

	localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	typedef struct packed {
		sample_t older;
		sample_t newer;
	} line_entry_t;

	typedef struct packed {
		logic row_ge1;
		logic row_ge2;
		logic col_ge1;
		logic col_ge2;
		logic has_right;
		logic last_row;
		logic last_col;
	} pos_flags_t;

	function automatic logic classify(
		input sample_t ctr,
		input logic hu, input sample_t u,
		input logic hd, input sample_t d,
		input logic hl, input sample_t l,
		input logic hr, input sample_t rt
	);
		logic above;
		logic higher;
		above  = (hu && (u < ctr)) || (hd && (d < ctr)) || (hl && (l < ctr)) || (hr && (rt < ctr));
		higher = (hu && (u > ctr)) || (hd && (d > ctr)) || (hl && (l > ctr)) || (hr && (rt > ctr));
		return above && !higher;
	endfunction

	line_entry_t line_mem [MAX_WIDTH];

	logic [SIZE_BITS-1:0] cur_row_q, cur_col_q;
	logic [SIZE_BITS-1:0] row_pos, col_pos, row_next, col_next;
	logic                 out_of_range, accept;
	pos_flags_t           flags;
	logic [ADDR_W-1:0]    rd_addr0, rd_addr1, wr_addr;
	line_entry_t          wr_entry;

	logic                 valid_s1;
	sample_t              sample_s1;
	logic [SIZE_BITS-1:0] row_s1, col_s1;
	pos_flags_t           flags_s1;
	line_entry_t          rd0_s1, rd1_s1, byp_data_s1;
	logic                 byp0_s1, byp1_s1;

	sample_t              prev_x_q, prev2_x_q, prev_newer_q;
	line_entry_t          cur_entry;
	sample_t              right_nb;
	logic                 pk_above, pk_left, pk_final;

	assign out_of_range = (cur_row_q >= frame_cfg.height) || (cur_col_q >= frame_cfg.width);
	assign row_pos  = out_of_range ? '0 : cur_row_q;
	assign col_pos  = out_of_range ? '0 : cur_col_q;
	assign row_next = row_pos + SIZE_BITS'(1);
	assign col_next = col_pos + SIZE_BITS'(1);

	assign flags.row_ge1   = (row_pos != '0);
	assign flags.row_ge2   = (row_pos >= SIZE_BITS'(2));
	assign flags.col_ge1   = (col_pos != '0);
	assign flags.col_ge2   = (col_pos >= SIZE_BITS'(2));
	assign flags.has_right = (col_next != frame_cfg.width);
	assign flags.last_row  = (row_next == frame_cfg.height);
	assign flags.last_col  = (col_next == frame_cfg.width);

	assign in_ready = (queue_level + QUEUE_COUNT_BITS'(valid_s1)) < QUEUE_COUNT_BITS'(QUEUE_DEPTH);
	assign accept   = in_valid && in_ready;

	assign rd_addr0 = ADDR_W'(col_pos);
	assign rd_addr1 = ADDR_W'(col_next);
	assign wr_addr  = ADDR_W'(col_s1);

	// forward the entry written this cycle to a read of the same column
	assign cur_entry = byp0_s1 ? byp_data_s1 : rd0_s1;
	assign right_nb  = byp1_s1 ? byp_data_s1.newer : rd1_s1.newer;

	assign wr_entry.older = cur_entry.newer;
	assign wr_entry.newer = sample_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
			valid_s1  <= 1'b0;
			byp0_s1   <= 1'b0;
			byp1_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			byp0_s1  <= valid_s1 && (wr_addr == rd_addr0);
			byp1_s1  <= valid_s1 && (wr_addr == rd_addr1);
			if (frame_cfg.restart) begin
				cur_row_q <= '0;
				cur_col_q <= '0;
			end else if (accept) begin
				if (flags.last_col) begin
					cur_col_q <= '0;
					cur_row_q <= flags.last_row ? '0 : row_next;
				end else begin
					cur_row_q <= row_pos;
					cur_col_q <= col_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			line_mem[wr_addr] <= wr_entry;
		end
		rd0_s1      <= line_mem[rd_addr0];
		rd1_s1      <= line_mem[rd_addr1];
		byp_data_s1 <= wr_entry;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= in_sample;
			row_s1    <= row_pos;
			col_s1    <= col_pos;
			flags_s1  <= flags;
		end
		if (valid_s1) begin
			prev2_x_q    <= prev_x_q;
			prev_x_q     <= sample_s1;
			prev_newer_q <= cur_entry.newer;
		end
	end

	assign pk_above = classify(cur_entry.newer,
		flags_s1.row_ge2, cur_entry.older,
		1'b1, sample_s1,
		flags_s1.col_ge1, prev_newer_q,
		flags_s1.has_right, right_nb);

	assign pk_left = classify(prev_x_q,
		flags_s1.row_ge1, prev_newer_q,
		1'b0, sample_s1,
		flags_s1.col_ge2, prev2_x_q,
		1'b1, sample_s1);

	assign pk_final = classify(sample_s1,
		flags_s1.row_ge1, cur_entry.newer,
		1'b0, sample_s1,
		flags_s1.col_ge1, prev_x_q,
		1'b0, sample_s1);

	always_comb begin
		push_set = '0;
		push_set.present[RES_ABOVE] = flags_s1.row_ge1;
		push_set.present[RES_LEFT]  = flags_s1.last_row && flags_s1.col_ge1;
		push_set.present[RES_FINAL] = flags_s1.last_row && flags_s1.last_col;
		push_set.peak[RES_ABOVE]    = pk_above;
		push_set.peak[RES_LEFT]     = pk_left;
		push_set.peak[RES_FINAL]    = pk_final;
		push_set.row                = ROW_BITS'(row_s1);
		push_set.col                = COL_BITS'(col_s1);
		push_set.val_above          = cur_entry.newer;
		push_set.val_left           = prev_x_q;
		push_set.val_final          = sample_s1;
	end

	assign push = valid_s1 && (push_set.present != '0);

endmodule

// ===== hdl/glpf_queue.sv =====
// Short queue of result sets between the front end and the output stage.
// Depends on glpf_pkg.
`timescale 1ns / 1ps
module glpf_queue import glpf_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  result_set_t                 push_set,
	input  logic                        pop,
	output logic                        head_valid,
	output result_set_t                 head_set,
	output logic [QUEUE_COUNT_BITS-1:0] level
);

	result_set_t                 slot_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]         wr_ptr_q, rd_ptr_q;
	logic [QUEUE_COUNT_BITS-1:0] count_q;

	assign head_valid = (count_q != '0);
	assign head_set   = slot_q[rd_ptr_q];
	assign level      = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QUEUE_COUNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QUEUE_COUNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_set;
		end
	end

endmodule

// ===== hdl/glpf_back.sv =====
// Output stage: splits each result set into words and drives the output register.
// Depends on glpf_pkg; pops glpf_queue as it loads the last word of a set.
`timescale 1ns / 1ps
module glpf_back import glpf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     head_valid,
	input  result_set_t              head_set,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [OUT_DATA_BITS-1:0] out_data,
	output logic                     out_peak,
	output logic                     out_last
);

	logic [RES_SLOTS-1:0] sent_q, rem, pick;
	logic                 last, load;
	out_word_t            word_d, word_q;
	logic                 peak_d, peak_q, last_q, valid_q;

	assign rem  = head_set.present & ~sent_q;
	assign pick = rem & (~rem + RES_SLOTS'(1));
	assign last = ((rem & ~pick) == '0);
	assign load = head_valid && (!valid_q || out_ready);
	assign pop  = load && last;

	always_comb begin
		word_d = '0;
		peak_d = 1'b0;
		if (pick[RES_ABOVE]) begin
			word_d.row   = head_set.row - ROW_BITS'(1);
			word_d.col   = head_set.col;
			word_d.value = head_set.val_above;
			peak_d       = head_set.peak[RES_ABOVE];
		end else if (pick[RES_LEFT]) begin
			word_d.row   = head_set.row;
			word_d.col   = head_set.col - COL_BITS'(1);
			word_d.value = head_set.val_left;
			peak_d       = head_set.peak[RES_LEFT];
		end else begin
			word_d.row   = head_set.row;
			word_d.col   = head_set.col;
			word_d.value = head_set.val_final;
			peak_d       = head_set.peak[RES_FINAL];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sent_q  <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sent_q  <= last ? '0 : (sent_q | pick);
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= word_d;
			peak_q <= peak_d;
			last_q <= last;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = word_q;
	assign out_peak  = peak_q;
	assign out_last  = last_q;

endmodule

// ===== hdl/glpf_checker.sv =====
// Port-level checker for the grid local peak finder, bound to the top level.
// Depends on glpf_pkg and grid_local_peak_finder_macros.svh.
`timescale 1ns / 1ps
`include "grid_local_peak_finder_macros.svh"
module glpf_checker import glpf_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_axis_tvalid,
	input logic                     s_axis_tready,
	input logic                     m_axis_tvalid,
	input logic                     m_axis_tready,
	input logic [OUT_DATA_BITS-1:0] m_axis_tdata,
	input logic                     m_axis_tuser,
	input logic                     m_axis_tlast
);

	logic [OUT_DATA_BITS+1:0] out_word;

	assign out_word = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

	`GLPF_ASSERT_HOLD(a_out_hold, m_axis_tvalid, m_axis_tready, out_word)
	`GLPF_ASSERT(a_first_latency, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 3), "output word without input word three edges before")
	`GLPF_ASSERT(a_run_continues, (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid, "gap inside the words of one sample")

endmodule

bind grid_local_peak_finder glpf_checker u_glpf_checker (.*);
